/* sv/life_pkg.sv */
// Shared types and constants for the Life row-step block.
`timescale 1ns / 1ps

package life_pkg;

    localparam int ROW_W = 64;
    localparam int CFG_W = 7;
    localparam int NBR_W = 4;

    localparam logic [NBR_W-1:0] BIRTH_COUNT   = NBR_W'(3);
    localparam logic [NBR_W-1:0] SURVIVE_COUNT = NBR_W'(2);

    localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(64);

    // One result word as it leaves the block.
    typedef struct packed {
        logic             last_of_frame;
        logic [ROW_W-1:0] changed_mask;
        logic [ROW_W-1:0] next_cells;
    } t_result;

    // Three-by-three neighborhood of one cell, each row ordered left, center, right.
    typedef struct packed {
        logic [2:0] up;
        logic [2:0] mid;
        logic [2:0] down;
    } t_window;

endpackage

/* sv/life_lane.sv */
// One cell of the Life stencil: neighbor count and the birth and survival rule.
`timescale 1ns / 1ps

module life_lane (
    input  life_pkg::t_window i_win,
    output logic              o_alive
);

    logic [life_pkg::NBR_W-1:0] nbr_count;

    always_comb begin
        nbr_count = life_pkg::NBR_W'(i_win.up[0]) + life_pkg::NBR_W'(i_win.up[1])
                  + life_pkg::NBR_W'(i_win.up[2]) + life_pkg::NBR_W'(i_win.mid[0])
                  + life_pkg::NBR_W'(i_win.mid[2]) + life_pkg::NBR_W'(i_win.down[0])
                  + life_pkg::NBR_W'(i_win.down[1]) + life_pkg::NBR_W'(i_win.down[2]);
        o_alive = (nbr_count == life_pkg::BIRTH_COUNT)
               || (i_win.mid[1] && (nbr_count == life_pkg::SURVIVE_COUNT));
    end

endmodule

/* sv/life_row_core.sv */
// Row of Life lanes, one per column, merged into the next-row and changed words.
`timescale 1ns / 1ps

module life_row_core #(
    parameter int LANES = 64
) (
    input  logic [life_pkg::ROW_W-1:0] i_up,
    input  logic [life_pkg::ROW_W-1:0] i_mid,
    input  logic [life_pkg::ROW_W-1:0] i_down,
    input  logic [life_pkg::ROW_W-1:0] i_mask,
    input  logic                       i_last,
    output life_pkg::t_result          o_result
);

    logic [life_pkg::ROW_W-1:0] lane_alive;

    genvar c;
    generate
        for (c = 0; c < life_pkg::ROW_W; c++) begin : g_col
            if (c < LANES) begin : g_lane
                life_pkg::t_window win;
                // Columns past either edge of the word are dead.
                always_comb begin
                    win.up[1]   = i_up[c];
                    win.mid[1]  = i_mid[c];
                    win.down[1] = i_down[c];
                    if (c > 0) begin
                        win.up[0]   = i_up[(c > 0) ? c - 1 : 0];
                        win.mid[0]  = i_mid[(c > 0) ? c - 1 : 0];
                        win.down[0] = i_down[(c > 0) ? c - 1 : 0];
                    end else begin
                        win.up[0]   = 1'b0;
                        win.mid[0]  = 1'b0;
                        win.down[0] = 1'b0;
                    end
                    if (c < life_pkg::ROW_W - 1) begin
                        win.up[2]   = i_up[(c < life_pkg::ROW_W - 1) ? c + 1 : c];
                        win.mid[2]  = i_mid[(c < life_pkg::ROW_W - 1) ? c + 1 : c];
                        win.down[2] = i_down[(c < life_pkg::ROW_W - 1) ? c + 1 : c];
                    end else begin
                        win.up[2]   = 1'b0;
                        win.mid[2]  = 1'b0;
                        win.down[2] = 1'b0;
                    end
                end
                life_lane u_lane (
                    .i_win   (win),
                    .o_alive (lane_alive[c])
                );
            end else begin : g_unused
                assign lane_alive[c] = 1'b0;
            end
        end
    endgenerate

    // Merge the lanes and apply the active-column mask.
    always_comb begin
        o_result.next_cells    = lane_alive & i_mask;
        o_result.changed_mask  = (lane_alive ^ i_mid) & i_mask;
        o_result.last_of_frame = i_last;
    end

endmodule

/* sv/life_out_fifo.sv */
// Two-word output queue that decouples the row engine from the output stall.
`timescale 1ns / 1ps

module life_out_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  life_pkg::t_result i_data,
    input  logic              i_pop,
    output logic              o_space,
    output logic              o_valid,
    output life_pkg::t_result o_data
);

    life_pkg::t_result r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;
    logic       do_pop;

    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;
    // A full queue still takes a word in the cycle its head leaves.
    assign o_space = (r_count != 2'd2) || i_pop;

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ do_pop;
        n_count  = r_count + 2'(i_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("output queue count out of range");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd2 && !i_pop) |-> !i_push)
        else $error("output queue written while full");

endmodule

/* sv/life_cellular_automaton_row_step.sv */
// Top level of the streaming Life row-step block.
// Usage:
//   The board enters on the s_axis channel one row per word: tdata holds row_cells,
//   bit c is column c, and tlast marks the bottom row. Results leave on m_axis:
//   tdata holds next_cells in bits 63:0 and changed_mask in bits 127:64, and tlast
//   carries last_of_frame. The cfg channel sets the column count; it is always ready
//   and should be written only while no board is in flight.
//   The top row of a board yields nothing; every later row, as it is taken, pushes the next
//   state of the row above it into the output queue. The bottom row yields a second
//   word, its own next state, in a flush step once the queue has room.
// Throughput: one row per cycle while the output queue has room, plus one flush step per board
//   in which the bottom row's own result runs through the single row of MAX_COLS lanes and no input is taken.
// Reset clears the held rows and the output queue and sets the column count to 64.
// When the receiver stalls, a two-word output queue absorbs the results in flight,
//   and s_axis tready drops once the queue has no room for the next word.
`timescale 1ns / 1ps

module life_cellular_automaton_row_step #(
    parameter int MAX_COLS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // tdata: row_cells[63:0]
    input  logic [life_pkg::ROW_W-1:0]          i_s_axis_tdata,
    input  logic                                i_s_axis_tlast,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata: next_cells[63:0], changed_mask[127:64]
    output logic [2*life_pkg::ROW_W-1:0]        o_m_axis_tdata,
    output logic                                o_m_axis_tlast,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    input  logic [life_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready
);

    logic [life_pkg::CFG_W-1:0] r_cols;
    logic [life_pkg::ROW_W-1:0] r_above;
    logic [life_pkg::ROW_W-1:0] r_middle;
    logic                       r_mid_valid;
    logic                       r_flush;

    logic [life_pkg::CFG_W-1:0] cols_eff;
    logic [life_pkg::ROW_W-1:0] col_mask;
    logic [life_pkg::ROW_W-1:0] row_in;
    logic [life_pkg::ROW_W-1:0] core_down;
    logic                       fifo_space;
    logic                       s_accept;
    logic                       flush_go;
    logic                       push;
    life_pkg::t_result          core_result;
    life_pkg::t_result          head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= life_pkg::COLS_RESET;
        end else if (i_cfg_valid) begin
            r_cols <= i_cfg_data;
        end
    end

    always_comb begin
        cols_eff = (r_cols > life_pkg::CFG_W'(MAX_COLS)) ? life_pkg::CFG_W'(MAX_COLS)
                                                         : r_cols;
        for (int c = 0; c < life_pkg::ROW_W; c++) begin
            col_mask[c] = (life_pkg::CFG_W'(c) < cols_eff);
        end
    end

    assign row_in          = i_s_axis_tdata & col_mask;
    assign o_s_axis_tready = fifo_space && !r_flush;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign flush_go        = r_flush && fifo_space;
    assign push            = flush_go || (s_accept && r_mid_valid);

    // During the flush cycle the row below the bottom row is dead.
    assign core_down = r_flush ? '0 : row_in;

    life_row_core #(
        .LANES (MAX_COLS)
    ) u_core (
        .i_up     (r_above),
        .i_mid    (r_middle),
        .i_down   (core_down),
        .i_mask   (col_mask),
        .i_last   (r_flush),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_above     <= '0;
            r_middle    <= '0;
            r_mid_valid <= 1'b0;
            r_flush     <= 1'b0;
        end else if (flush_go) begin
            r_above     <= '0;
            r_middle    <= '0;
            r_mid_valid <= 1'b0;
            r_flush     <= 1'b0;
        end else if (s_accept) begin
            r_above     <= r_mid_valid ? r_middle : '0;
            r_middle    <= row_in;
            r_mid_valid <= 1'b1;
            r_flush     <= i_s_axis_tlast;
        end
    end

    life_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (core_result),
        .i_pop   (i_m_axis_tready),
        .o_space (fifo_space),
        .o_valid (o_m_axis_tvalid),
        .o_data  (head)
    );

    assign o_m_axis_tdata = {head.changed_mask, head.next_cells};
    assign o_m_axis_tlast = head.last_of_frame;

    a_flush_has_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> r_mid_valid)
        else $error("flush pending without a held row");
    a_empty_above: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_mid_valid |-> (r_above == '0))
        else $error("row above not cleared between boards");
    a_last_starts_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_s_axis_tlast) |=> r_flush)
        else $error("bottom row did not start the flush");

endmodule
